[hdl/gbm_pkg.sv]
// ----------------------------------------------------------------------------
// gbm_pkg
// Shared field widths, types and register indexes of the Goertzel bin meter.
// ----------------------------------------------------------------------------
package gbm_pkg;

    // fixed field widths
    localparam int COEFF_W     = 18;
    localparam int GAIN_W      = 16;
    localparam int SAMPLE_W    = 11;
    localparam int MAG_W       = 26;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 18;

    // entries between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [COEFF_W-1:0]  coeff_t;
    typedef logic        [GAIN_W-1:0]   gain_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [MAG_W-1:0]    mag_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    // top of the magnitude range
    localparam mag_t MAG_MAX = '1;

    // register indexes
    localparam cfg_index_t CFG_BIN_COEFF  = CFG_INDEX_W'(0);
    localparam cfg_index_t CFG_METER_GAIN = CFG_INDEX_W'(1);

endpackage

[hdl/gbm_front.sv]
// ----------------------------------------------------------------------------
// gbm_front
// Sample side: runs the Goertzel recursion with one shared multiplier and,
// at the end of a block, hands the final state and coeff*q1 to the queue.
// ----------------------------------------------------------------------------
module gbm_front #(
    parameter int COEFF_FRAC_BITS = 16,
    parameter int STATE_BITS      = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  gbm_pkg::sample_t          sample,
    input  logic                      last_sample,
    input  gbm_pkg::coeff_t           bin_coeff,
    output logic                      push_valid,
    input  logic                      push_ready,
    output logic [3*STATE_BITS-1:0]   push_data
);

    localparam int SB = STATE_BITS;
    localparam int F  = COEFF_FRAC_BITS;
    localparam int H  = (SB + 1) / 2;
    localparam int HW = SB - H;
    localparam int PW = gbm_pkg::COEFF_W + H + 1;
    localparam int FW = gbm_pkg::COEFF_W + SB + 1;
    localparam int UW = ((SB > gbm_pkg::SAMPLE_W + F) ? SB : gbm_pkg::SAMPLE_W + F) + 2;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_PUSH   = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic signed [SB-1:0]    q1_reg, q1_next;
    logic signed [SB-1:0]    q2_reg, q2_next;
    logic                    last_reg, last_next;
    logic                    final_reg, final_next;
    gbm_pkg::sample_t        smp_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    part_reg;
    logic signed [SB-1:0]    cq_reg;

    logic signed [H:0]       mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [FW-1:0]    full_prod;
    logic signed [FW-1:0]    scaled;
    logic [FW-SB:0]          scaled_top;
    logic signed [SB-1:0]    cq_sat;
    logic signed [UW-1:0]    upd_sum;
    logic [UW-SB:0]          upd_top;
    logic signed [SB-1:0]    upd_sat;

    // multiplier operand: low half unsigned, high half signed
    always_comb
    begin
        if (state_reg == ST_MUL_HI)
        begin
            mul_b = {{(H+1-HW){q1_reg[SB-1]}}, q1_reg[SB-1:H]};
        end
        else
        begin
            mul_b = {1'b0, q1_reg[H-1:0]};
        end
    end

    assign mul_p = bin_coeff * mul_b;

    // recombine halves, floor shift, saturate to state width
    assign full_prod  = (FW'(prod_reg) <<< H) + FW'(part_reg);
    assign scaled     = full_prod >>> F;
    assign scaled_top = scaled[FW-1:SB-1];
    assign cq_sat     = ((&scaled_top) || !(|scaled_top)) ? scaled[SB-1:0]
                      : (scaled[FW-1] ? S_MIN : S_MAX);

    // recursion sum with saturation
    assign upd_sum = UW'(cq_reg) - UW'(q2_reg) + (UW'(smp_reg) <<< F);
    assign upd_top = upd_sum[UW-1:SB-1];
    assign upd_sat = ((&upd_top) || !(|upd_top)) ? upd_sum[SB-1:0]
                   : (upd_sum[UW-1] ? S_MIN : S_MAX);

    assign in_stall   = (state_reg != ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_data  = {q1_reg, q2_reg, cq_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        last_next  = last_reg;
        final_next = final_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = last_sample;
                    final_next = 1'b0;
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = final_reg ? ST_PUSH : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                q2_next = q1_reg;
                q1_next = upd_sat;
                if (last_reg)
                begin
                    final_next = 1'b1;
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    q1_next    = '0;
                    q2_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and recursion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            q1_reg    <= '0;
            q2_reg    <= '0;
            last_reg  <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q1_reg    <= q1_next;
            q2_reg    <= q2_next;
            last_reg  <= last_next;
            final_reg <= final_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            smp_reg <= sample;
        end
        if (state_reg == ST_MUL_LO || state_reg == ST_MUL_HI)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL_HI)
        begin
            part_reg <= prod_reg;
        end
        if (state_reg == ST_SCALE)
        begin
            cq_reg <= cq_sat;
        end
    end

endmodule

[hdl/gbm_fifo.sv]
// ----------------------------------------------------------------------------
// gbm_fifo
// Short queue of finished block states between the front and the back.
// ----------------------------------------------------------------------------
module gbm_fifo #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/gbm_back.sv]
// ----------------------------------------------------------------------------
// gbm_back
// Result side: power from half-width partial products, bit-serial integer
// square root, bit-serial division by the gain, output word register.
// ----------------------------------------------------------------------------
module gbm_back #(
    parameter int COEFF_FRAC_BITS = 16,
    parameter int STATE_BITS      = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  logic [3*STATE_BITS-1:0]   pop_data,
    input  gbm_pkg::gain_t            meter_gain,
    output logic                      out_valid,
    input  logic                      out_stall,
    output gbm_pkg::mag_t             magnitude
);

    localparam int SB  = STATE_BITS;
    localparam int F   = COEFF_FRAC_BITS;
    localparam int H   = (SB + 1) / 2;
    localparam int AW  = 2 * SB + 2;
    localparam int DW  = SB - F;
    localparam int QW  = (DW > gbm_pkg::MAG_W) ? DW : gbm_pkg::MAG_W;
    localparam int GW  = gbm_pkg::GAIN_W;
    localparam int CNW = $clog2(SB + 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_ACC  = 3'd2;
    localparam logic [2:0] B_SQRT = 3'd3;
    localparam logic [2:0] B_DIV  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    localparam logic [1:0] TERM_Q1 = 2'd0;
    localparam logic [1:0] TERM_Q2 = 2'd1;
    localparam logic [1:0] TERM_CQ = 2'd2;
    localparam logic [3:0] LAST_STEP = 4'd11;

    logic [2:0]            state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            step_reg;
    logic [SB-1:0]         mag_q1_reg, mag_q2_reg, mag_c_reg;
    logic                  tsub_reg;
    logic [2*H-1:0]        prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [2*SB-1:0]       n_reg;
    logic [SB:0]           rem_reg;
    logic [SB-1:0]         root_reg;
    logic [CNW-1:0]        cnt_reg;
    logic [GW-1:0]         drem_reg;
    logic [DW-1:0]         quo_reg;
    gbm_pkg::mag_t         mag_reg;

    logic [SB-1:0]         q1_raw, q2_raw, c_raw;
    logic [SB-1:0]         op_a, op_b;
    logic [H-1:0]          half_a, half_b;
    logic [2*H-1:0]        mul_p;
    logic signed [AW-1:0]  pp_shift;
    logic signed [AW-1:0]  acc_next;
    logic [2*SB-1:0]       power;
    logic [SB+2:0]         rem_sh, trial, rem_diff;
    logic                  sq_ge;
    logic [SB:0]           rem_next;
    logic [SB-1:0]         root_next;
    gbm_pkg::gain_t        gain_eff;
    logic [GW:0]           dr_sh, dr_diff;
    logic                  dv_ge;
    logic [GW-1:0]         drem_next;
    logic [QW-1:0]         quo_ext;
    gbm_pkg::mag_t         mag_sat;
    logic                  out_free;

    assign q1_raw = pop_data[3*SB-1:2*SB];
    assign q2_raw = pop_data[2*SB-1:SB];
    assign c_raw  = pop_data[SB-1:0];

    assign pop_ready = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // operands of the current power term
    always_comb
    begin
        unique case (step_reg[3:2])
            TERM_Q1:
            begin
                op_a = mag_q1_reg;
                op_b = mag_q1_reg;
            end
            TERM_Q2:
            begin
                op_a = mag_q2_reg;
                op_b = mag_q2_reg;
            end
            default:
            begin
                op_a = mag_c_reg;
                op_b = mag_q2_reg;
            end
        endcase
    end

    // one partial product of the two halves
    assign half_a = step_reg[1] ? H'(op_a[SB-1:H]) : op_a[H-1:0];
    assign half_b = step_reg[0] ? H'(op_b[SB-1:H]) : op_b[H-1:0];
    assign mul_p  = half_a * half_b;

    // align and accumulate; the cross term is subtracted when its sign says so
    always_comb
    begin
        unique case (step_reg[1:0])
            2'b00:   pp_shift = AW'(prod_reg);
            2'b11:   pp_shift = AW'(prod_reg) << (2 * H);
            default: pp_shift = AW'(prod_reg) << H;
        endcase
    end

    assign acc_next = (step_reg[3:2] == TERM_CQ && tsub_reg) ? acc_reg - pp_shift
                                                             : acc_reg + pp_shift;
    assign power    = acc_next[AW-1] ? '0 : acc_next[2*SB-1:0];

    // square root, one result bit per cycle
    assign rem_sh    = {rem_reg, n_reg[2*SB-1:2*SB-2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sq_ge     = (rem_sh >= trial);
    assign rem_diff  = rem_sh - trial;
    assign rem_next  = sq_ge ? rem_diff[SB:0] : rem_sh[SB:0];
    assign root_next = {root_reg[SB-2:0], sq_ge};

    // restoring division by the gain, zero gain acts as one
    assign gain_eff  = (meter_gain == '0) ? GW'(1) : meter_gain;
    assign dr_sh     = {drem_reg, quo_reg[DW-1]};
    assign dv_ge     = (dr_sh >= {1'b0, gain_eff});
    assign dr_diff   = dr_sh - {1'b0, gain_eff};
    assign drem_next = dv_ge ? dr_diff[GW-1:0] : dr_sh[GW-1:0];

    // clamp quotient to the magnitude range
    assign quo_ext = QW'(quo_reg);
    assign mag_sat = (quo_ext > QW'(gbm_pkg::MAG_MAX)) ? gbm_pkg::MAG_MAX
                                                       : quo_ext[gbm_pkg::MAG_W-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_ACC;
            end
            B_ACC:
            begin
                state_next = (step_reg == LAST_STEP) ? B_SQRT : B_MUL;
            end
            B_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                mag_q1_reg <= q1_raw[SB-1] ? (~q1_raw + 1'b1) : q1_raw;
                mag_q2_reg <= q2_raw[SB-1] ? (~q2_raw + 1'b1) : q2_raw;
                mag_c_reg  <= c_raw[SB-1] ? (~c_raw + 1'b1) : c_raw;
                tsub_reg   <= (c_raw[SB-1] == q2_raw[SB-1]);
                acc_reg    <= '0;
                step_reg   <= '0;
            end
            B_MUL:
            begin
                prod_reg <= mul_p;
            end
            B_ACC:
            begin
                acc_reg  <= acc_next;
                step_reg <= step_reg + 1'b1;
                n_reg    <= power;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNW'(SB - 1);
            end
            B_SQRT:
            begin
                n_reg    <= n_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg - 1'b1;
                quo_reg  <= root_next[SB-1:F];
                drem_reg <= '0;
                if (cnt_reg == '0)
                begin
                    cnt_reg <= CNW'(DW - 1);
                end
            end
            B_DIV:
            begin
                drem_reg <= drem_next;
                quo_reg  <= {quo_reg[DW-2:0], dv_ge};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    mag_reg <= mag_sat;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

endmodule

[hdl/goertzel_bin_magnitude.sv]
// ----------------------------------------------------------------------------
// goertzel_bin_magnitude
// Goertzel single-bin magnitude detector: recursion front, result queue,
// power / square root / gain division back, configuration registers.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   --------------------------------
//  input     in_valid / in_stall    sample, last_sample
//  output    out_valid / out_stall  magnitude
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  The front runs each sample as two halves through the one
//  18 x (STATE_BITS/2+1) multiplier, a scale and an update; the last
//  sample of a block then forms coeff*q1 of the final state and queues
//  it. The back takes a new block only once idle: 12 partial products,
//  bit-serial root and division. The front stalls input while busy.
//  Asynchronous reset clears the recursion state, the queue and the output.
//  Output stall holds the word; the back and two queue entries keep working.
//
module goertzel_bin_magnitude #(
    parameter int COEFF_FRAC_BITS = 16,
    parameter int STATE_BITS      = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  gbm_pkg::sample_t      sample,
    input  logic                  last_sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output gbm_pkg::mag_t         magnitude,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  gbm_pkg::cfg_index_t   cfg_index,
    input  gbm_pkg::cfg_data_t    cfg_data
);

    localparam int EW = 3 * STATE_BITS;

    gbm_pkg::coeff_t  bin_coeff_reg;
    gbm_pkg::gain_t   meter_gain_reg;

    logic             push_valid, push_ready;
    logic [EW-1:0]    push_data;
    logic             pop_valid, pop_ready;
    logic [EW-1:0]    pop_data;

    assign cfg_ready = 1'b1;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_coeff_reg  <= '0;
            meter_gain_reg <= gbm_pkg::GAIN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == gbm_pkg::CFG_BIN_COEFF)
            begin
                bin_coeff_reg <= signed'(cfg_data[gbm_pkg::COEFF_W-1:0]);
            end
            else if (cfg_index == gbm_pkg::CFG_METER_GAIN)
            begin
                meter_gain_reg <= cfg_data[gbm_pkg::GAIN_W-1:0];
            end
        end
    end

    gbm_front #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .STATE_BITS      (STATE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .bin_coeff   (bin_coeff_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    gbm_fifo #(
        .WIDTH (EW),
        .DEPTH (gbm_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    gbm_back #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .STATE_BITS      (STATE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .meter_gain (meter_gain_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .magnitude  (magnitude)
    );

endmodule

[tb/bin_magnitude_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bin_magnitude_checker
// Watches the sample, result and register channels of the Goertzel bin meter.
// Runs its own copy of the recursion and the power / root / gain stage and
// compares each accepted magnitude word with the oldest predicted one.
// ----------------------------------------------------------------------------
module bin_magnitude_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  gbm_pkg::sample_t     sample,
    input  logic                 last_sample,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  gbm_pkg::mag_t        magnitude,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  gbm_pkg::cfg_index_t  cfg_index,
    input  gbm_pkg::cfg_data_t   cfg_data,
    output int unsigned          fail_count,
    output int unsigned          pending_count
);

    localparam int FRAC = 16;
    localparam int SW   = 48;

    typedef logic signed [SW-1:0]  state_t;
    typedef logic signed [127:0]   wide_t;

    localparam wide_t STATE_HI = 128'sh7fff_ffff_ffff;
    localparam wide_t STATE_LO = -STATE_HI - 1;

    // shadow registers and recursion state
    gbm_pkg::coeff_t coeff_reg;
    gbm_pkg::gain_t  gain_reg;
    state_t          q1;
    state_t          q2;
    gbm_pkg::mag_t   expected_mag[$];
    gbm_pkg::mag_t   want;

    function automatic state_t clamp_state(input wide_t v);
        if (v > STATE_HI)
            return STATE_HI[SW-1:0];
        if (v < STATE_LO)
            return STATE_LO[SW-1:0];
        return v[SW-1:0];
    endfunction

    // coeff * q, scaled back by the fraction bits (floor), saturated
    function automatic state_t scale_by_coeff(input state_t q);
        wide_t a;
        wide_t b;
        a = coeff_reg;
        b = q;
        return clamp_state((a * b) >>> FRAC);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = {64'd0, r | (64'd1 << i)};
            if (c * c <= n)
                r = c[63:0];
        end
        return r;
    endfunction

    // power of the final state, rooted, divided by gain
    function automatic gbm_pkg::mag_t block_magnitude(input state_t a, input state_t b);
        wide_t       w1;
        wide_t       w2;
        wide_t       wc;
        wide_t       pw;
        logic [63:0] root;
        logic [63:0] divisor;
        logic [63:0] quot;
        w1 = a;
        w2 = b;
        wc = scale_by_coeff(a);
        pw = w1 * w1 + w2 * w2 - wc * w2;
        if (pw < 0)
            pw = '0;
        root = int_sqrt(pw);
        divisor = (gain_reg == '0) ? 64'd1 : 64'(gain_reg);
        quot = (root >> FRAC) / divisor;
        return (quot > 64'(gbm_pkg::MAG_MAX)) ? gbm_pkg::MAG_MAX
                                              : quot[gbm_pkg::MAG_W-1:0];
    endfunction

    task automatic recur_step(input gbm_pkg::sample_t s, input logic last);
        wide_t acc;
        wide_t prev2;
        wide_t smp;
        prev2 = q2;
        smp = s;
        acc = scale_by_coeff(q1);
        acc = acc - prev2 + (smp <<< FRAC);
        q2 = q1;
        q1 = clamp_state(acc);
        if (last)
        begin
            expected_mag.push_back(block_magnitude(q1, q2));
            q1 = '0;
            q2 = '0;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            coeff_reg = '0;
            gain_reg = 16'd1;
            q1 = '0;
            q2 = '0;
            expected_mag.delete();
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gbm_pkg::CFG_BIN_COEFF)
                    coeff_reg = cfg_data;
                else if (cfg_index == gbm_pkg::CFG_METER_GAIN)
                    gain_reg = cfg_data[gbm_pkg::GAIN_W-1:0];
            end
            // sample word taken
            if (in_valid && !in_stall)
                recur_step(sample, last_sample);
            // magnitude word taken
            if (out_valid && !out_stall)
            begin
                if (expected_mag.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: magnitude expected none, actual %0d", $time, magnitude);
                end
                else
                begin
                    want = expected_mag.pop_front();
                    if (magnitude !== want)
                    begin
                        fail_count++;
                        $display("%0t: magnitude expected %0d, actual %0d",
                                 $time, want, magnitude);
                    end
                end
            end
        end
        pending_count = expected_mag.size();
    end

endmodule

[tb/tb_goertzel_bin_magnitude.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_goertzel_bin_magnitude
// Drives sample blocks and register settings into the Goertzel bin meter
// with random idle and stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_goertzel_bin_magnitude;

    localparam int                  SETTLE_CYCLES    = 160;
    localparam int                  PHASES           = 12;
    localparam int                  PHASE_WORDS      = 112;
    localparam gbm_pkg::cfg_index_t CFG_UNUSED_INDEX = gbm_pkg::cfg_index_t'(9);
    localparam gbm_pkg::coeff_t     COEFF_TOP        = gbm_pkg::coeff_t'(131071);
    localparam gbm_pkg::coeff_t     COEFF_BOTTOM     = gbm_pkg::coeff_t'(-131072);
    localparam gbm_pkg::sample_t    SAMPLE_TOP       = gbm_pkg::sample_t'(1023);
    localparam gbm_pkg::sample_t    SAMPLE_BOTTOM    = gbm_pkg::sample_t'(-1024);

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    gbm_pkg::sample_t     sample      = '0;
    logic                 last_sample = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    gbm_pkg::mag_t        magnitude;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    gbm_pkg::cfg_index_t  cfg_index   = '0;
    gbm_pkg::cfg_data_t   cfg_data    = '0;
    int unsigned          fail_count;
    int unsigned          pending_count;

    bit                   quiet_in    = 1'b0;
    bit                   quiet_out   = 1'b0;
    gbm_pkg::coeff_t      cur_coeff   = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    goertzel_bin_magnitude dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .magnitude   (magnitude),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    bin_magnitude_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .last_sample   (last_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .magnitude     (magnitude),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // result side back-pressure
    always @(posedge clk)
        out_stall <= !quiet_out && ($urandom_range(99) < 32);

    task automatic send_sample(input gbm_pkg::sample_t s, input logic last);
        while (!quiet_in && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last_sample <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input gbm_pkg::cfg_index_t idx, input gbm_pkg::cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == gbm_pkg::CFG_BIN_COEFF)
            cur_coeff = val;
    endtask

    // hold the sender until every magnitude is back and the front is idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int               sent;
        int               len;
        bit               long_block;
        gbm_pkg::sample_t s;
        gbm_pkg::gain_t   g;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: mid coefficient, unit gain, full-scale swings
        write_reg(gbm_pkg::CFG_METER_GAIN, gbm_pkg::cfg_data_t'(1));
        write_reg(gbm_pkg::CFG_BIN_COEFF,
                  gbm_pkg::cfg_data_t'(gbm_pkg::coeff_t'(92682)));
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_BOTTOM, 1'b0);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_BOTTOM, 1'b1);
        // one-sample blocks
        send_sample(SAMPLE_BOTTOM, 1'b1);
        send_sample(SAMPLE_TOP, 1'b1);

        // top coefficient, zero gain acts as one
        drain();
        write_reg(gbm_pkg::CFG_BIN_COEFF, gbm_pkg::cfg_data_t'(COEFF_TOP));
        write_reg(gbm_pkg::CFG_METER_GAIN, gbm_pkg::cfg_data_t'(0));
        repeat (3) send_sample(SAMPLE_TOP, 1'b0);
        send_sample(SAMPLE_TOP, 1'b1);

        // bottom coefficient, largest gain, spare data bits set
        drain();
        write_reg(gbm_pkg::CFG_BIN_COEFF, gbm_pkg::cfg_data_t'(COEFF_BOTTOM));
        write_reg(gbm_pkg::CFG_METER_GAIN, gbm_pkg::cfg_data_t'(18'h3ffff));
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample(SAMPLE_BOTTOM, 1'b0);
        send_sample(SAMPLE_TOP, 1'b0);
        send_sample(SAMPLE_BOTTOM, 1'b1);

        // write to an unused index is dropped
        drain();
        write_reg(CFG_UNUSED_INDEX, gbm_pkg::cfg_data_t'($urandom));
        write_reg(gbm_pkg::CFG_BIN_COEFF, gbm_pkg::cfg_data_t'(0));
        write_reg(gbm_pkg::CFG_METER_GAIN, gbm_pkg::cfg_data_t'(1));
        send_sample(SAMPLE_BOTTOM, 1'b0);
        send_sample(SAMPLE_BOTTOM, 1'b1);
        send_sample('0, 1'b1);

        // random phases, one coefficient and gain setting each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            quiet_in = (ph == 5 || ph == 6);
            quiet_out = (ph == 6 || ph == 7);
            case ($urandom_range(5))
                0: write_reg(gbm_pkg::CFG_BIN_COEFF, gbm_pkg::cfg_data_t'(COEFF_TOP));
                1: write_reg(gbm_pkg::CFG_BIN_COEFF, gbm_pkg::cfg_data_t'(COEFF_BOTTOM));
                2: write_reg(gbm_pkg::CFG_BIN_COEFF,
                             gbm_pkg::cfg_data_t'(COEFF_TOP - $urandom_range(2000)));
                default: write_reg(gbm_pkg::CFG_BIN_COEFF, gbm_pkg::cfg_data_t'($urandom));
            endcase
            case ($urandom_range(7))
                0, 1: g = 16'd1;
                2: g = '0;
                3: g = 16'hffff;
                4, 5: g = gbm_pkg::gain_t'($urandom_range(1, 16));
                default: g = gbm_pkg::gain_t'($urandom);
            endcase
            write_reg(gbm_pkg::CFG_METER_GAIN, {2'($urandom), g});
            if (ph % 3 == 0)
                write_reg(CFG_UNUSED_INDEX, gbm_pkg::cfg_data_t'($urandom));

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                long_block = ($urandom_range(7) == 0);
                len = long_block ? $urandom_range(60, 130) : $urandom_range(1, 24);
                for (int k = 0; k < len; k++)
                begin
                    // long blocks drive the bin at resonance to reach saturation
                    if (long_block)
                        s = (cur_coeff < 0 && k % 2 == 1) ? SAMPLE_BOTTOM : SAMPLE_TOP;
                    else
                        case ($urandom_range(7))
                            0: s = SAMPLE_TOP;
                            1: s = SAMPLE_BOTTOM;
                            2, 3: s = gbm_pkg::sample_t'($urandom_range(16))
                                      - gbm_pkg::sample_t'(8);
                            default: s = gbm_pkg::sample_t'($urandom);
                        endcase
                    send_sample(s, k == len - 1);
                end
                sent += len;
            end
        end

        drain();
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
